### rtl/wtok_pkg.sv
// Shared definitions for the word tokenizer: result kinds, error codes,
// character codes and the default token buffer size. No dependencies.
package wtok_pkg;

    localparam int TOKEN_BUFFER_SIZE_DEF = 64;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int LINE_W  = 16;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2,
        KIND_EOI  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_GRAMMAR = 2'd1,
        ERR_PREMAT  = 2'd2,
        ERR_OVERRUN = 2'd3
    } t_err;

    localparam logic [BYTE_W-1:0] CH_LF     = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'd34;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'd40;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'd41;
    localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'd97;
    localparam logic [BYTE_W-1:0] CH_LOW_Z  = 8'd122;
    localparam logic [BYTE_W-1:0] CASE_OFS  = 8'd32;

endpackage

### rtl/wtok_in_if.sv
// Input channel of the word tokenizer: one source byte or end mark per transfer.
// Depends on wtok_pkg for field widths.
interface wtok_in_if import wtok_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

### rtl/wtok_out_if.sv
// Result channel of the word tokenizer: one result item per transfer.
// Depends on wtok_pkg for field types and widths.
interface wtok_out_if import wtok_pkg::*; ();
    logic              valid;
    logic              ready;
    t_kind             kind;
    logic [BYTE_W-1:0] out_byte;
    logic              is_string;
    logic [LEN_W-1:0]  token_length;
    t_err              error_code;
    logic [LINE_W-1:0] line_number;

    modport source (output valid, output kind, output out_byte, output is_string,
                    output token_length, output error_code, output line_number,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input is_string,
                    input token_length, input error_code, input line_number,
                    output ready);
endinterface

### rtl/word_tokenizer_with_comments.sv
// Word tokenizer with quoted strings and parenthesized comments (top level).
// Each result is registered: it appears on the output register in the cycle after its input transfer.
// Throughput: one input transfer per cycle; the scan state updates in the same cycle,
// so only a stalled, full output register holds the input back.
// Reset (synchronous, active low) returns to word mode with zero counts and an empty
// output register. Depends on wtok_pkg, wtok_in_if and wtok_out_if.
module word_tokenizer_with_comments
    import wtok_pkg::*;
#(
    parameter int TOKEN_BUFFER_SIZE = TOKEN_BUFFER_SIZE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wtok_in_if.sink      i_in,
    wtok_out_if.source   o_out
);

    // The character counter only has to reach TOKEN_BUFFER_SIZE - 1, since a
    // character that would reach the buffer size is an overflow error instead.
    localparam int CNT_W = (TOKEN_BUFFER_SIZE > 2) ? $clog2(TOKEN_BUFFER_SIZE) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOKEN_BUFFER_SIZE - 1);

    typedef enum logic [1:0] {
        MODE_WORD    = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_COMMENT = 2'd2,
        MODE_HALTED  = 2'd3
    } t_mode;

    // Scan state.
    t_mode             r_mode,  n_mode;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [LINE_W-1:0] r_line,  n_line;

    // Output register.
    logic              r_valid;
    t_kind             r_kind,   n_kind;
    logic [BYTE_W-1:0] r_byte,   n_byte;
    logic              r_str,    n_str;
    logic [LEN_W-1:0]  r_len,    n_len;
    t_err              r_err,    n_err;
    logic [LINE_W-1:0] r_lnum;

    logic              accept;
    logic              emit;
    logic [LINE_W-1:0] line_inc;
    logic [CNT_W+LEN_W-1:0] len_wide;
    logic [LEN_W-1:0]  count_len;

    // The input is taken whenever the output register is empty or drains this
    // cycle, so a waiting result blocks the next byte only while the output is stalled.
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Saturating line counter increment.
    assign line_inc = (r_line == '1) ? r_line : r_line + LINE_W'(1);

    // The token length field is six bits wide whatever the counter width is.
    assign len_wide  = {{LEN_W{1'b0}}, r_count};
    assign count_len = len_wide[LEN_W-1:0];

    // One pass of the scanner over the current byte and the current mode.
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_line  = r_line;
        emit    = 1'b0;
        n_kind  = KIND_CHAR;
        n_byte  = '0;
        n_str   = 1'b0;
        n_len   = '0;
        n_err   = ERR_NONE;

        case (r_mode)
            MODE_STRING: begin
                n_str = 1'b1;
                if (i_in.end_of_input) begin
                    emit = 1'b1; n_kind = KIND_ERR; n_err = ERR_PREMAT; n_str = 1'b0;
                    n_mode = MODE_HALTED;
                end else if (i_in.in_byte == CH_LF || i_in.in_byte == CH_CR) begin
                    emit = 1'b1; n_kind = KIND_ERR; n_err = ERR_GRAMMAR; n_str = 1'b0;
                    n_mode = MODE_HALTED;
                end else if (i_in.in_byte == CH_QUOTE) begin
                    // Closing quote ends the string token, even an empty one.
                    emit = 1'b1; n_kind = KIND_END; n_len = count_len;
                    n_count = '0;
                    n_mode  = MODE_WORD;
                end else if (r_count >= CNT_LAST) begin
                    emit = 1'b1; n_kind = KIND_ERR; n_err = ERR_OVERRUN; n_str = 1'b0;
                    n_mode = MODE_HALTED;
                end else begin
                    // String bytes pass through without case change.
                    emit = 1'b1; n_kind = KIND_CHAR; n_byte = i_in.in_byte;
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_COMMENT: begin
                // Comments produce nothing except errors.
                if (i_in.end_of_input) begin
                    emit = 1'b1; n_kind = KIND_ERR; n_err = ERR_PREMAT;
                    n_mode = MODE_HALTED;
                end else if (i_in.in_byte == CH_LPAREN) begin
                    emit = 1'b1; n_kind = KIND_ERR; n_err = ERR_GRAMMAR;
                    n_mode = MODE_HALTED;
                end else if (i_in.in_byte == CH_LF) begin
                    n_line = line_inc;
                end else if (i_in.in_byte == CH_RPAREN) begin
                    n_mode = MODE_WORD;
                end
            end
            MODE_WORD: begin
                if (i_in.end_of_input) begin
                    // End of input flushes the pending word length and stays in word mode.
                    emit = 1'b1; n_kind = KIND_EOI; n_len = count_len;
                    n_count = '0;
                end else if (i_in.in_byte == CH_LF || i_in.in_byte == CH_SPACE) begin
                    if (i_in.in_byte == CH_LF) begin
                        n_line = line_inc;
                    end
                    if (r_count != '0) begin
                        emit = 1'b1; n_kind = KIND_END; n_len = count_len;
                        n_count = '0;
                    end
                end else if (i_in.in_byte == CH_CR) begin
                    n_mode = MODE_WORD;
                end else if (i_in.in_byte == CH_QUOTE) begin
                    // A quote is only legal at the start of a token.
                    if (r_count != '0) begin
                        emit = 1'b1; n_kind = KIND_ERR; n_err = ERR_GRAMMAR;
                        n_mode = MODE_HALTED;
                    end else begin
                        n_mode = MODE_STRING;
                    end
                end else if (i_in.in_byte == CH_LPAREN) begin
                    n_mode = MODE_COMMENT;
                end else if (i_in.in_byte == CH_RPAREN) begin
                    emit = 1'b1; n_kind = KIND_ERR; n_err = ERR_GRAMMAR;
                    n_mode = MODE_HALTED;
                end else if (r_count >= CNT_LAST) begin
                    emit = 1'b1; n_kind = KIND_ERR; n_err = ERR_OVERRUN;
                    n_mode = MODE_HALTED;
                end else begin
                    // Word characters are upper-cased, ASCII letters only.
                    emit = 1'b1; n_kind = KIND_CHAR;
                    n_count = r_count + CNT_W'(1);
                    if (i_in.in_byte >= CH_LOW_A && i_in.in_byte <= CH_LOW_Z) begin
                        n_byte = i_in.in_byte - CASE_OFS;
                    end else begin
                        n_byte = i_in.in_byte;
                    end
                end
            end
            default: begin
                // Halted: every byte is swallowed until reset.
                n_mode = MODE_HALTED;
            end
        endcase
    end

    // Scan state advances only on an input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_WORD;
            r_count <= '0;
            r_line  <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_line  <= n_line;
        end
    end

    // Output register: reloads whenever it is empty or its result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_str  <= n_str;
            r_len  <= n_len;
            r_err  <= n_err;
            r_lnum <= n_line;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_kind;
    assign o_out.out_byte     = r_byte;
    assign o_out.is_string    = r_str;
    assign o_out.token_length = r_len;
    assign o_out.error_code   = r_err;
    assign o_out.line_number  = r_lnum;

endmodule

### sim/tb_top.sv
// Self-checking testbench for word_tokenizer_with_comments: drives byte streams and
// compares each result transfer with an in-bench token predictor.
// Depends on rtl/wtok_pkg.sv, rtl/wtok_in_if.sv, rtl/wtok_out_if.sv and the top level.
module tb_top;
    import wtok_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKEN_BUF = TOKEN_BUFFER_SIZE_DEF;
    localparam int MAX_CHARS = TOKEN_BUF - 1;

    // Scan modes of the predictor, in the same order as the block's own state.
    typedef enum logic [1:0] {
        SCAN_WORD    = 2'd0,
        SCAN_STRING  = 2'd1,
        SCAN_COMMENT = 2'd2,
        SCAN_HALTED  = 2'd3
    } t_scan_mode;

    // Ways to stop the block with an error at the end of the run.
    typedef enum int {
        FAULT_QUOTE_IN_WORD,
        FAULT_STRAY_CLOSE,
        FAULT_NESTED_COMMENT,
        FAULT_CR_IN_STRING,
        FAULT_LF_IN_STRING,
        FAULT_WORD_OVERFLOW,
        FAULT_STRING_OVERFLOW,
        FAULT_EOI_IN_STRING,
        FAULT_EOI_IN_COMMENT,
        FAULT_COUNT
    } t_fault;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] out_byte;
        logic              is_string;
        logic [LEN_W-1:0]  token_length;
        t_err              error_code;
        logic [LINE_W-1:0] line_number;
    } t_tok_result;

    logic i_clk;
    logic i_rst_n;

    wtok_in_if  in_if ();
    wtok_out_if out_if ();

    word_tokenizer_with_comments #(
        .TOKEN_BUFFER_SIZE(TOKEN_BUF)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state: a copy of the scanner's mode, token length and line count.
    t_scan_mode        scan_mode;
    int unsigned       tok_len;
    logic [LINE_W-1:0] lines_seen;

    t_tok_result expected_results[$];
    int          n_errors;
    int          sent_items;
    // Percent chance of an idle burst before each transfer, shared by both sides.
    int          idle_pct;

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic t_tok_result make_result(t_kind k, logic [BYTE_W-1:0] ch, logic str,
                                                int unsigned len, t_err err);
        t_tok_result r;
        r.kind         = k;
        r.out_byte     = ch;
        r.is_string    = str;
        r.token_length = len[LEN_W-1:0];
        r.error_code   = err;
        r.line_number  = lines_seen;
        return r;
    endfunction

    // Any error reports once and then freezes the scanner until reset.
    function automatic t_tok_result halt_with(t_err err);
        scan_mode = SCAN_HALTED;
        return make_result(KIND_ERR, 8'h00, 1'b0, 0, err);
    endfunction

    function automatic void count_line();
        if (lines_seen != {LINE_W{1'b1}}) lines_seen++;
    endfunction

    // Advances the predictor by one accepted input and returns 1 when it yields a result.
    function automatic bit predict_token(logic [BYTE_W-1:0] ch, logic eoi,
                                         output t_tok_result r);
        int unsigned       len;
        logic [BYTE_W-1:0] up;
        r = '0;
        case (scan_mode)
            SCAN_HALTED: begin
                return 0;
            end
            SCAN_STRING: begin
                if (eoi) begin
                    r = halt_with(ERR_PREMAT);
                    return 1;
                end
                if (ch == CH_LF || ch == CH_CR) begin
                    r = halt_with(ERR_GRAMMAR);
                    return 1;
                end
                if (ch == CH_QUOTE) begin
                    len       = tok_len;
                    tok_len   = 0;
                    scan_mode = SCAN_WORD;
                    r = make_result(KIND_END, 8'h00, 1'b1, len, ERR_NONE);
                    return 1;
                end
                if (tok_len >= MAX_CHARS) begin
                    r = halt_with(ERR_OVERRUN);
                    return 1;
                end
                tok_len++;
                r = make_result(KIND_CHAR, ch, 1'b1, 0, ERR_NONE);
                return 1;
            end
            SCAN_COMMENT: begin
                if (eoi) begin
                    r = halt_with(ERR_PREMAT);
                    return 1;
                end
                if (ch == CH_LPAREN) begin
                    r = halt_with(ERR_GRAMMAR);
                    return 1;
                end
                if (ch == CH_LF) count_line();
                else if (ch == CH_RPAREN) scan_mode = SCAN_WORD;
                return 0;
            end
            default: begin
                if (eoi) begin
                    len     = tok_len;
                    tok_len = 0;
                    r = make_result(KIND_EOI, 8'h00, 1'b0, len, ERR_NONE);
                    return 1;
                end
                if (ch == CH_LF || ch == CH_SPACE) begin
                    if (ch == CH_LF) count_line();
                    if (tok_len == 0) return 0;
                    len     = tok_len;
                    tok_len = 0;
                    r = make_result(KIND_END, 8'h00, 1'b0, len, ERR_NONE);
                    return 1;
                end
                if (ch == CH_CR) return 0;
                if (ch == CH_QUOTE) begin
                    if (tok_len > 0) begin
                        r = halt_with(ERR_GRAMMAR);
                        return 1;
                    end
                    scan_mode = SCAN_STRING;
                    return 0;
                end
                if (ch == CH_LPAREN) begin
                    scan_mode = SCAN_COMMENT;
                    return 0;
                end
                if (ch == CH_RPAREN) begin
                    r = halt_with(ERR_GRAMMAR);
                    return 1;
                end
                if (tok_len >= MAX_CHARS) begin
                    r = halt_with(ERR_OVERRUN);
                    return 1;
                end
                tok_len++;
                up = ch;
                if (ch >= CH_LOW_A && ch <= CH_LOW_Z) up = ch - CASE_OFS;
                r = make_result(KIND_CHAR, up, 1'b0, 0, ERR_NONE);
                return 1;
            end
        endcase
    endfunction

    // Trial step on the predictor: true when the input would not stop the block.
    function automatic bit is_safe(logic [BYTE_W-1:0] ch, logic eoi);
        t_scan_mode        m = scan_mode;
        int unsigned       n = tok_len;
        logic [LINE_W-1:0] l = lines_seen;
        t_tok_result       r;
        bit                has;
        has        = predict_token(ch, eoi, r);
        scan_mode  = m;
        tok_len    = n;
        lines_seen = l;
        return !(has && r.kind == KIND_ERR);
    endfunction

    // ---------------------------------------------------------------- driving

    // Sends one item; the expectation is recorded at the edge where the transfer happens.
    // Called and left at a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] ch, input logic eoi);
        t_tok_result r;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.in_byte      <= ch;
        in_if.end_of_input <= eoi;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (predict_token(ch, eoi, r)) expected_results.push_back(r);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // A byte that is an ordinary word character; lower-case letters are favored.
    function automatic logic [BYTE_W-1:0] word_char();
        logic [BYTE_W-1:0] c;
        if ($urandom_range(0, 2) == 0) return CH_LOW_A + BYTE_W'($urandom_range(0, 25));
        do c = BYTE_W'($urandom_range(0, 255));
        while (c inside {CH_LF, CH_CR, CH_SPACE, CH_QUOTE, CH_LPAREN, CH_RPAREN});
        return c;
    endfunction

    // The result side stalls in bursts, with the same odds as the sender.
    initial begin
        out_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // Every result transfer is matched against the oldest outstanding expectation.
    always @(posedge i_clk) begin : result_check
        t_tok_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d, out_byte %0d", out_if.kind,
                       out_if.out_byte);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, out_if.kind);
                check_field("out_byte", want.out_byte, out_if.out_byte);
                check_field("is_string", want.is_string, out_if.is_string);
                check_field("token_length", want.token_length, out_if.token_length);
                check_field("error_code", want.error_code, out_if.error_code);
                check_field("line_number", want.line_number, out_if.line_number);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Case folding at the edges of a-z, 0x00 and 0xFF as data, each separator,
    // an empty string, a string keeping its case and a '(' as data, a comment with
    // an LF inside a word, and end of input with and without a pending word.
    task automatic test_directed();
        send_text("aZ");
        send_byte(8'h60, 1'b0);
        send_text("{ ");
        send_byte(8'h00, 1'b0);
        send_text("z");
        send_byte(8'hFF, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_text("\"\"");
        send_text("\"a( \"");
        send_text("q(x");
        send_byte(CH_LF, 1'b0);
        send_text(")r");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic send_word(input int unsigned n);
        if (n > MAX_CHARS - tok_len) n = MAX_CHARS - tok_len;
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) send_byte(CH_CR, 1'b0);
            send_byte(word_char(), 1'b0);
        end
    endtask

    task automatic send_string(input int unsigned n);
        logic [BYTE_W-1:0] c;
        if (tok_len != 0) send_byte(CH_SPACE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        repeat (n) begin
            do c = BYTE_W'($urandom_range(0, 255));
            while (c inside {CH_LF, CH_CR, CH_QUOTE});
            send_byte(c, 1'b0);
        end
        send_byte(CH_QUOTE, 1'b0);
    endtask

    // A comment may fall inside a word; the word just goes on after it.
    task automatic send_comment(input int unsigned n);
        logic [BYTE_W-1:0] c;
        send_byte(CH_LPAREN, 1'b0);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) c = CH_LF;
            else do c = BYTE_W'($urandom_range(0, 255));
                 while (c inside {CH_LPAREN, CH_RPAREN});
            send_byte(c, 1'b0);
        end
        send_byte(CH_RPAREN, 1'b0);
    endtask

    // Random bytes that are legal wherever the scanner happens to be; an open string
    // or comment is closed afterwards so the next segment starts in word mode.
    task automatic send_noise(input int unsigned n);
        logic [BYTE_W-1:0] c;
        logic              e;
        repeat (n) begin
            do begin
                c = BYTE_W'($urandom_range(0, 255));
                e = ($urandom_range(0, 15) == 0);
            end while (!is_safe(c, e));
            send_byte(c, e);
        end
        if (scan_mode == SCAN_STRING) send_byte(CH_QUOTE, 1'b0);
        else if (scan_mode == SCAN_COMMENT) send_byte(CH_RPAREN, 1'b0);
    endtask

    // Well-formed source with random content; full-length tokens show up now and then.
    task automatic test_random_stream(input int n_items);
        int stop_at;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2: send_word($urandom_range(0, 19) == 0 ? MAX_CHARS
                                                              : $urandom_range(1, 10));
                3, 4: send_string($urandom_range(0, 19) == 0 ? MAX_CHARS
                                                             : $urandom_range(0, 10));
                5: send_comment($urandom_range(0, 8));
                6, 7: begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 2))
                            0: send_byte(CH_SPACE, 1'b0);
                            1: send_byte(CH_LF, 1'b0);
                            default: send_byte(CH_CR, 1'b0);
                        endcase
                    end
                end
                8: send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
                default: send_noise($urandom_range(1, 6));
            endcase
        end
    endtask

    // One error per run (reset is applied only once), picked by the seed; afterwards
    // the block must stay silent whatever it is fed. A space first ends any pending
    // word so that the chosen fault is the one that fires.
    task automatic test_error_halt();
        t_fault f;
        f = t_fault'($urandom_range(0, FAULT_COUNT - 1));
        send_byte(CH_SPACE, 1'b0);
        case (f)
            FAULT_QUOTE_IN_WORD:  send_text("ab\"");
            FAULT_STRAY_CLOSE:    send_text(")");
            FAULT_NESTED_COMMENT: send_text("(a(");
            FAULT_CR_IN_STRING: begin
                send_text("\"a");
                send_byte(CH_CR, 1'b0);
            end
            FAULT_LF_IN_STRING: begin
                send_text("\"a");
                send_byte(CH_LF, 1'b0);
            end
            FAULT_WORD_OVERFLOW: repeat (TOKEN_BUF) send_byte("x", 1'b0);
            FAULT_STRING_OVERFLOW: begin
                send_byte(CH_QUOTE, 1'b0);
                repeat (TOKEN_BUF) send_byte("x", 1'b0);
            end
            FAULT_EOI_IN_STRING: begin
                send_text("\"a");
                send_byte(8'h00, 1'b1);
            end
            default: begin
                send_text("(a");
                send_byte(8'h00, 1'b1);
            end
        endcase
        repeat (8) send_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.in_byte      = '0;
        in_if.end_of_input = 1'b0;
        scan_mode          = SCAN_WORD;
        tok_len            = 0;
        lines_seen         = '0;
        n_errors           = 0;
        sent_items         = 0;
        idle_pct           = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_pct = 30;
        test_directed();
        test_random_stream(1750);

        // The closing part runs without idling on either side.
        idle_pct = 0;
        test_error_halt();
        in_if.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: the slowest correct run stays well under a tenth of this.
    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

endmodule
